FILE: hdl/block_satd_hadamard4x4_top_assert.svh
// Assertion macros shared by the SATD block, clocked on clk, off during reset.
`ifndef BLOCK_SATD_HADAMARD4X4_TOP_ASSERT_SVH
`define BLOCK_SATD_HADAMARD4X4_TOP_ASSERT_SVH

// Same-cycle implication.
`define SATD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SATD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/satd_pkg.sv
// Shared types and constants of the 4x4 Hadamard SATD block.
`timescale 1ns / 1ps
package satd_pkg;

  // Block shape codes
  localparam logic [2:0] SHAPE_4X4   = 3'd0;
  localparam logic [2:0] SHAPE_8X8   = 3'd1;
  localparam logic [2:0] SHAPE_16X8  = 3'd2;
  localparam logic [2:0] SHAPE_8X16  = 3'd3;

  // Last row of a 4x4 sub-block
  localparam logic [1:0] ROW_LAST = 2'd3;

  // Control of the row stage, seen by the lanes and the merge stage
  typedef struct packed {
    logic       vld;
    logic [1:0] row;
  } satd_ctl_t;

  // Sub-blocks per total; unused codes count as 16x16
  function automatic logic [4:0] target_count(input logic [2:0] shape);
    logic [4:0] cnt;
    unique case (shape)
      SHAPE_4X4:  cnt = 5'd1;
      SHAPE_8X8:  cnt = 5'd4;
      SHAPE_16X8: cnt = 5'd8;
      SHAPE_8X16: cnt = 5'd8;
      default:    cnt = 5'd16;
    endcase
    return cnt;
  endfunction

endpackage

FILE: hdl/satd_row.sv
// Row stage: pixel differences, horizontal 4-point Hadamard, row counter.
`timescale 1ns / 1ps
module satd_row #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          advance,
  input  logic [PIXEL_BITS-1:0]         src_pix [4],
  input  logic [PIXEL_BITS-1:0]         ref_pix [4],
  output satd_pkg::satd_ctl_t           ctl,
  output logic signed [PIXEL_BITS+2:0]  row_coef [4]
);
  import satd_pkg::*;

  localparam int DW = PIXEL_BITS + 1;
  localparam int RW = PIXEL_BITS + 3;

  logic signed [DW-1:0] diff [4];
  logic signed [RW-1:0] s0, s1, d0, d1;
  logic signed [RW-1:0] coef_nxt [4];
  logic signed [RW-1:0] coef_r [4];
  logic [1:0]           row_cnt_r;
  satd_ctl_t            ctl_r;

  // Take differences and transform across the row
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff[i] = $signed({1'b0, src_pix[i]}) - $signed({1'b0, ref_pix[i]});
    end
    s0 = RW'(diff[0]) + RW'(diff[2]);
    s1 = RW'(diff[1]) + RW'(diff[3]);
    d0 = RW'(diff[0]) - RW'(diff[2]);
    d1 = RW'(diff[1]) - RW'(diff[3]);
    coef_nxt[0] = s0 + s1;
    coef_nxt[1] = d0 + d1;
    coef_nxt[2] = d0 - d1;
    coef_nxt[3] = s0 - s1;
  end

  // Advance the row stage; count rows of each request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= '0;
      row_cnt_r <= '0;
    end else if (advance) begin
      ctl_r.vld <= in_fire;
      if (in_fire) begin
        ctl_r.row <= row_cnt_r;
        row_cnt_r <= row_cnt_r + 2'd1;
      end
    end
  end

  // Hold coefficients with their row
  always_ff @(posedge clk) begin
    if (in_fire) begin
      coef_r <= coef_nxt;
    end
  end

  assign ctl      = ctl_r;
  assign row_coef = coef_r;

endmodule

FILE: hdl/satd_lane.sv
// Column lane: holds three row coefficients, then vertical Hadamard and abs sum.
`timescale 1ns / 1ps
module satd_lane #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          advance,
  input  satd_pkg::satd_ctl_t           ctl,
  input  logic signed [PIXEL_BITS+2:0]  coef,
  output logic [PIXEL_BITS+6:0]         lane_sum
);
  import satd_pkg::*;

  localparam int RW = PIXEL_BITS + 3;
  localparam int CW = PIXEL_BITS + 5;
  localparam int SW = PIXEL_BITS + 7;

  logic signed [RW-1:0] col_r [3];
  logic signed [CW-1:0] s0, s1, d0, d1;
  logic signed [CW-1:0] vc [4];
  logic [CW-1:0]        mag [4];
  logic [SW-1:0]        sum_nxt;
  logic [SW-1:0]        sum_r;

  // Transform down the column and sum magnitudes
  always_comb begin
    s0 = CW'(col_r[0]) + CW'(col_r[2]);
    s1 = CW'(col_r[1]) + CW'(coef);
    d0 = CW'(col_r[0]) - CW'(col_r[2]);
    d1 = CW'(col_r[1]) - CW'(coef);
    vc[0] = s0 + s1;
    vc[1] = d0 + d1;
    vc[2] = d0 - d1;
    vc[3] = s0 - s1;
    for (int i = 0; i < 4; i++) begin
      mag[i] = vc[i][CW-1] ? CW'(-vc[i]) : CW'(vc[i]);
    end
    sum_nxt = SW'(mag[0]) + SW'(mag[1]) + SW'(mag[2]) + SW'(mag[3]);
  end

  // Store rows 0..2, register the sum on the last row
  always_ff @(posedge clk) begin
    if (advance && ctl.vld) begin
      unique case (ctl.row)
        2'd0:     col_r[0] <= coef;
        2'd1:     col_r[1] <= coef;
        2'd2:     col_r[2] <= coef;
        ROW_LAST: sum_r    <= sum_nxt;
      endcase
    end
  end

  assign lane_sum = sum_r;

endmodule

FILE: hdl/satd_merge.sv
// Merge stage: add lane sums, round half, accumulate sub-blocks, output register.
`timescale 1ns / 1ps
module satd_merge #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [2:0]                 shape,
  input  satd_pkg::satd_ctl_t        ctl,
  input  logic [PIXEL_BITS+6:0]      lane_sum [4],
  output logic                       advance,
  output logic                       s2_vld,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [PIXEL_BITS+10:0]     out_total
);
  import satd_pkg::*;

  localparam int BW = PIXEL_BITS + 9;
  localparam int TW = PIXEL_BITS + 11;

  logic          s2_vld_r;
  logic [3:0]    sub_cnt_r;
  logic [TW-1:0] total_r;
  logic [TW-1:0] out_total_r;
  logic          out_valid_r;
  logic [BW-1:0] blk_sum;
  logic [BW-1:0] half;
  logic [TW-1:0] total_nxt;
  logic          done;
  logic          emit;
  logic          stall;

  // Combine lanes, round and test for the last sub-block
  always_comb begin
    blk_sum   = BW'(lane_sum[0]) + BW'(lane_sum[1]) + BW'(lane_sum[2]) + BW'(lane_sum[3]);
    half      = (blk_sum + BW'(1)) >> 1;
    total_nxt = total_r + TW'(half);
    done      = ({1'b0, sub_cnt_r} + 5'd1) >= target_count(shape);
    emit      = s2_vld_r && done;
    stall     = emit && out_valid_r && !out_ready;
  end

  // Advance the block-sum stage, the accumulator and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      sub_cnt_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!stall) begin
        s2_vld_r <= ctl.vld && (ctl.row == ROW_LAST);
      end
      if (s2_vld_r && !stall) begin
        if (done) begin
          total_r   <= '0;
          sub_cnt_r <= '0;
        end else begin
          total_r   <= total_nxt;
          sub_cnt_r <= sub_cnt_r + 4'd1;
        end
      end
      if (emit && !stall) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (emit && !stall) begin
      out_total_r <= total_nxt;
    end
  end

  assign advance   = !stall;
  assign s2_vld    = s2_vld_r;
  assign out_valid = out_valid_r;
  assign out_total = out_total_r;

endmodule

FILE: hdl/block_satd_hadamard4x4_top.sv
// Top level of the 4x4 Hadamard SATD block.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_src_pix0..3, in_ref_pix0..3
//  out     | output    | out_valid / out_ready  | out_satd_total
//  cfg     | input     | cfg_we                 | cfg_wdata (block shape)
//
// One row request is taken per cycle while the pipe does not stall; four lanes, one per column, run side by side.
// The row that closes the last sub-block passes the row register, lane sum and output register to give a total.
// The pipe stalls only when a total is ready while the previous one waits.
// Reset (rst_n low, synchronous) clears counters, accumulator and shape to 4x4.
`timescale 1ns / 1ps
`include "block_satd_hadamard4x4_top_assert.svh"
module block_satd_hadamard4x4_top #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIXEL_BITS-1:0]  in_src_pix0,
  input  logic [PIXEL_BITS-1:0]  in_src_pix1,
  input  logic [PIXEL_BITS-1:0]  in_src_pix2,
  input  logic [PIXEL_BITS-1:0]  in_src_pix3,
  input  logic [PIXEL_BITS-1:0]  in_ref_pix0,
  input  logic [PIXEL_BITS-1:0]  in_ref_pix1,
  input  logic [PIXEL_BITS-1:0]  in_ref_pix2,
  input  logic [PIXEL_BITS-1:0]  in_ref_pix3,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIXEL_BITS+10:0] out_satd_total,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_wdata
);
  import satd_pkg::*;

  logic                         advance;
  logic                         in_fire;
  logic                         s2_vld;
  logic [2:0]                   shape_r;
  logic [PIXEL_BITS-1:0]        src_pix [4];
  logic [PIXEL_BITS-1:0]        ref_pix [4];
  logic signed [PIXEL_BITS+2:0] row_coef [4];
  logic [PIXEL_BITS+6:0]        lane_sum [4];
  satd_ctl_t                    ctl;

  assign in_ready = advance;
  assign in_fire  = in_valid && advance;

  assign src_pix[0] = in_src_pix0;
  assign src_pix[1] = in_src_pix1;
  assign src_pix[2] = in_src_pix2;
  assign src_pix[3] = in_src_pix3;
  assign ref_pix[0] = in_ref_pix0;
  assign ref_pix[1] = in_ref_pix1;
  assign ref_pix[2] = in_ref_pix2;
  assign ref_pix[3] = in_ref_pix3;

  // Hold the block shape
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHAPE_4X4;
    end else if (cfg_we) begin
      shape_r <= cfg_wdata;
    end
  end

  satd_row #(.PIXEL_BITS(PIXEL_BITS)) u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .advance  (advance),
    .src_pix  (src_pix),
    .ref_pix  (ref_pix),
    .ctl      (ctl),
    .row_coef (row_coef)
  );

  // One lane per column
  for (genvar g = 0; g < 4; g++) begin : g_lane
    satd_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
      .clk      (clk),
      .advance  (advance),
      .ctl      (ctl),
      .coef     (row_coef[g]),
      .lane_sum (lane_sum[g])
    );
  end

  satd_merge #(.PIXEL_BITS(PIXEL_BITS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .shape     (shape_r),
    .ctl       (ctl),
    .lane_sum  (lane_sum),
    .advance   (advance),
    .s2_vld    (s2_vld),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_total (out_satd_total)
  );

  // Stall only while a total waits in the output register
  `SATD_ASSERT_NOW(a_stall_needs_out, !in_ready, out_valid && !out_ready, "stall without waiting total")
  // A last row that advances reaches the block-sum stage
  `SATD_ASSERT_NEXT(a_last_row_moves, ctl.vld && (ctl.row == ROW_LAST) && advance, s2_vld, "last row lost")
  // A new total comes only from a completed sub-block
  `SATD_ASSERT_NOW(a_total_source, $rose(out_valid), $past(s2_vld), "total without sub-block")

endmodule
